// ===== design/afl_pkg.sv =====
`default_nettype none

package afl_pkg;

  localparam int SampleWidth = 16;
  localparam int WeightWidth = 8;
  localparam int ThreshWidth = 16;
  localparam int CfgDataWidth = 16;
  localparam int CfgAddrWidth = 2;

  // Q0.8 rounding: (d*w + half) >> 8
  localparam int WeightShift = 8;
  localparam logic [SampleWidth+WeightWidth-1:0] RoundHalf = 24'd128;

  localparam logic [ThreshWidth-1:0] ThreshReset = 16'd0;
  localparam logic [WeightWidth-1:0] FixedWeightReset = 8'd128;
  localparam logic [WeightWidth-1:0] WeightMaxReset = 8'd255;
  localparam logic [WeightWidth-1:0] WeightStepReset = 8'd20;

  typedef enum logic [CfgAddrWidth-1:0] {
    REG_ACCEL_THRESHOLD = 2'd0,
    REG_FIXED_WEIGHT    = 2'd1,
    REG_WEIGHT_MAX      = 2'd2,
    REG_WEIGHT_STEP     = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    logic [ThreshWidth-1:0] accel_threshold;
    logic [WeightWidth-1:0] fixed_weight;
    logic [WeightWidth-1:0] weight_max;
    logic [WeightWidth-1:0] weight_step;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/afl_cfg.sv =====
`default_nettype none

module afl_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [afl_pkg::CfgAddrWidth-1:0]    cfg_addr,
  input  wire logic [afl_pkg::CfgDataWidth-1:0]    cfg_wdata,
  output afl_pkg::cfg_t                            cfg
);
  import afl_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.accel_threshold <= ThreshReset;
      regs.fixed_weight    <= FixedWeightReset;
      regs.weight_max      <= WeightMaxReset;
      regs.weight_step     <= WeightStepReset;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_ACCEL_THRESHOLD: regs.accel_threshold <= cfg_wdata[ThreshWidth-1:0];
        REG_FIXED_WEIGHT:    regs.fixed_weight    <= cfg_wdata[WeightWidth-1:0];
        REG_WEIGHT_MAX:      regs.weight_max      <= cfg_wdata[WeightWidth-1:0];
        REG_WEIGHT_STEP:     regs.weight_step     <= cfg_wdata[WeightWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== design/afl_core.sv =====
`default_nettype none

// Filter state plus the combinational update. State advances when 'step' is high.
module afl_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               step,
  input  wire logic [afl_pkg::SampleWidth-1:0]    sample,
  input  wire afl_pkg::cfg_t                      cfg,
  output logic [afl_pkg::SampleWidth-1:0]         filtered_next,
  output logic [afl_pkg::WeightWidth-1:0]         weight_next
);
  import afl_pkg::*;

  localparam int ProdWidth = SampleWidth + WeightWidth;

  logic [SampleWidth-1:0] last_output;
  dir_t                   last_direction;
  logic [WeightWidth-1:0] adaptive_weight;

  dir_t                   dir;
  logic [SampleWidth-1:0] diff;
  logic                   adaptive;
  logic [WeightWidth-1:0] incr;
  logic [WeightWidth:0]   sum;
  logic [WeightWidth-1:0] adapt_next;
  logic [WeightWidth-1:0] w;
  logic [ProdWidth-1:0]   prod;
  logic [SampleWidth-1:0] delta;

  always_comb begin
    if (sample > last_output) begin
      dir  = DIR_UP;
      diff = sample - last_output;
    end else if (sample < last_output) begin
      dir  = DIR_DOWN;
      diff = last_output - sample;
    end else begin
      dir  = DIR_NONE;
      diff = '0;
    end
  end

  assign adaptive = (cfg.accel_threshold != '0);
  assign incr     = (diff > cfg.accel_threshold) ? cfg.weight_step : WeightWidth'(1);
  // 9-bit sum tops out at 510, so no wrap; just clamp to the max
  assign sum      = {1'b0, adaptive_weight} + {1'b0, incr};

  always_comb begin
    if (dir != last_direction) begin
      adapt_next = '0;
    end else if (sum > {1'b0, cfg.weight_max}) begin
      adapt_next = cfg.weight_max;
    end else begin
      adapt_next = sum[WeightWidth-1:0];
    end
  end

  assign w     = adaptive ? adapt_next : cfg.fixed_weight;
  assign prod  = ProdWidth'(diff) * ProdWidth'(w) + RoundHalf;
  assign delta = prod[WeightShift +: SampleWidth];

  always_comb begin
    case (dir)
      DIR_UP:   filtered_next = last_output + delta;
      DIR_DOWN: filtered_next = last_output - delta;
      default:  filtered_next = last_output;
    endcase
  end

  assign weight_next = w;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_output     <= '0;
      last_direction  <= DIR_NONE;
      adaptive_weight <= '0;
    end else if (step) begin
      last_output <= filtered_next;
      if (adaptive) begin
        last_direction  <= dir;
        adaptive_weight <= adapt_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/adaptive_first_order_lag_filter.sv =====
`default_nettype none

// Adaptive first-order lag filter. Each 16-bit sample request yields one result
// request holding the new filtered value and the weight (out of 256) applied:
// filtered = old +/- ((|sample - old| * w + 128) >> 8). With accel_threshold
// zero the weight is fixed_weight; otherwise it grows while the direction of
// change repeats (by weight_step for changes above the threshold, else by one,
// clamped to weight_max) and drops to zero when the direction flips.
// Throughput is one sample per clock while results are taken without stalls.
// A sample is held in the input register, then makes one pass through the
// subtract / weight update / 16x8 multiply path into the output register,
// which raises output valid; a stalled result holds it in the input register.
// The filter state feeds back within that single pass, which sets the rate.
// Configuration writes take effect on the next clock and are meant to be made
// only while the block is empty.
module adaptive_first_order_lag_filter (
  input  wire logic        clk,
  input  wire logic        rst,

  // sample requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample

  // result requests
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] filtered, [23:16] weight_now

  // register writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,       // 0 thresh, 1 fixed wt, 2 max wt, 3 step
  input  wire logic [15:0] cfg_wdata
);
  import afl_pkg::*;

  cfg_t cfg;

  // input stage
  logic                   in_valid;
  logic [SampleWidth-1:0] in_sample;

  // output stage
  logic                   out_valid;
  logic [SampleWidth-1:0] out_filtered;
  logic [WeightWidth-1:0] out_weight;

  logic                   advance;
  logic                   in_fire;
  logic [SampleWidth-1:0] filtered_next;
  logic [WeightWidth-1:0] weight_next;

  // An item moves from the input register to the output register whenever
  // the output register is empty or being drained this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || advance);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  afl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  afl_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .sample        (in_sample),
    .cfg           (cfg),
    .filtered_next (filtered_next),
    .weight_next   (weight_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_sample <= s_axis_tdata[SampleWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_filtered <= filtered_next;
      out_weight   <= weight_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_weight, out_filtered};

endmodule

`default_nettype wire

// ===== design/afl_checker.sv =====
`default_nettype none

module afl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  logic        s_fire;
  logic        m_fire;
  logic [15:0] prev_filtered;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  // last filtered value handed out; the filter state starts at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_filtered <= '0;
    end else if (m_fire) begin
      prev_filtered <= m_axis_tdata[15:0];
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_fire, 2))
    else $error("result without a sample two cycles earlier");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("sample stalled with empty output");

  a_zero_weight_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[23:16] == 8'd0) |-> m_axis_tdata[15:0] == prev_filtered)
    else $error("zero weight moved the filtered value");

endmodule

bind adaptive_first_order_lag_filter afl_checker u_afl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afl_pkg::*;

  // quiet cycles allowed before the run is declared hung; the slowest legal
  // request needs the longest send gap, the longest sink stall and the pass
  // through the pipeline, so this is far beyond any correct stretch
  localparam int QuietLimit = 200;
  localparam int RandPhases = 16;
  localparam int PhaseItems = 125;

  // one result request: filtered value and the weight that produced it
  typedef struct packed {
    logic [WeightWidth-1:0] weight;
    logic [SampleWidth-1:0] filtered;
  } lag_result_t;

  // Tracks the filter state and register values, and holds the results
  // still owed by the block.
  class lag_filter_tracker;
    logic [ThreshWidth-1:0] thresh;
    logic [WeightWidth-1:0] fixed_wt;
    logic [WeightWidth-1:0] max_wt;
    logic [WeightWidth-1:0] step_wt;
    logic [SampleWidth-1:0] last_out;
    dir_t                   last_dir;
    logic [WeightWidth-1:0] adapt_wt;
    lag_result_t            owed_results[$];
    int n_samples, n_checked, n_errors, n_fixed, n_adaptive, peak_wt;

    function new();
      thresh     = ThreshReset;
      fixed_wt   = FixedWeightReset;
      max_wt     = WeightMaxReset;
      step_wt    = WeightStepReset;
      last_out   = '0;
      last_dir   = DIR_NONE;
      adapt_wt   = '0;
      n_samples  = 0;
      n_checked  = 0;
      n_errors   = 0;
      n_fixed    = 0;
      n_adaptive = 0;
      peak_wt    = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [CfgDataWidth-1:0] val);
      case (idx)
        REG_ACCEL_THRESHOLD: thresh = val;
        REG_FIXED_WEIGHT:    fixed_wt = val[WeightWidth-1:0];
        REG_WEIGHT_MAX:      max_wt = val[WeightWidth-1:0];
        REG_WEIGHT_STEP:     step_wt = val[WeightWidth-1:0];
        default: ;
      endcase
    endfunction

    // note an accepted sample and queue the result it must produce
    function void take_sample(logic [SampleWidth-1:0] s);
      logic [SampleWidth-1:0] d;
      dir_t dir;
      logic [WeightWidth:0] sum;
      logic [WeightWidth-1:0] w;
      logic [SampleWidth+WeightWidth-1:0] prod;
      lag_result_t r;
      d   = '0;
      dir = DIR_NONE;
      if (s > last_out) begin
        d   = s - last_out;
        dir = DIR_UP;
      end else if (s < last_out) begin
        d   = last_out - s;
        dir = DIR_DOWN;
      end
      if (thresh != '0) begin
        if (dir == last_dir) begin
          // 9-bit sum never wraps, then clamp
          sum = {1'b0, adapt_wt} + ((d > thresh) ? {1'b0, step_wt} : 9'd1);
          if (sum > {1'b0, max_wt}) sum = {1'b0, max_wt};
          adapt_wt = sum[WeightWidth-1:0];
        end else begin
          adapt_wt = '0;
        end
        last_dir = dir;
        w = adapt_wt;
        n_adaptive++;
        if (int'(w) > peak_wt) peak_wt = int'(w);
      end else begin
        w = fixed_wt;
        n_fixed++;
      end
      prod = {8'b0, d} * {16'b0, w} + RoundHalf;
      case (dir)
        DIR_UP:   last_out = last_out + prod[SampleWidth+WeightWidth-1:WeightShift];
        DIR_DOWN: last_out = last_out - prod[SampleWidth+WeightWidth-1:WeightShift];
        default: ;
      endcase
      r.filtered = last_out;
      r.weight   = w;
      owed_results.push_back(r);
      n_samples++;
    endfunction

    // compare one accepted result with the oldest owed one
    function void check_output(logic [23:0] data);
      lag_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result %h arrived with no sample outstanding", $time, data);
        n_errors++;
        return;
      end
      want = owed_results.pop_front();
      n_checked++;
      if (data[15:0] !== want.filtered) begin
        $display("%0t: filtered mismatch: expected %h, actual %h",
                 $time, want.filtered, data[15:0]);
        n_errors++;
      end
      if (data[23:16] !== want.weight) begin
        $display("%0t: weight_now mismatch: expected %0d, actual %0d",
                 $time, want.weight, data[23:16]);
        n_errors++;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // [15:0] sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;    // [15:0] filtered, [23:16] weight_now
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  lag_filter_tracker sb;
  bit idle_on;        // random gaps/stalls enabled in the current phase
  bit trend_up;       // direction of the current ramp in random stimulus
  int n_settings;
  int quiet_cycles;

  adaptive_first_order_lag_filter uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor: both handshakes sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.take_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
    end
  end

  // Watchdog: any request or register write counts as progress.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: watchdog, no traffic for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result sink: a random stall, when idling is enabled, before taking each result.
  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // tvalid is only lowered when a gap is drawn, so it never toggles in one step.
  task automatic send_sample(logic [15:0] s);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
  endtask

  // Sender holds off until every owed result is back, plus pipeline slack.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_config(logic [15:0] thr, logic [7:0] fw, logic [7:0] wm,
                              logic [7:0] ws);
    drain_results();
    write_reg(REG_ACCEL_THRESHOLD, thr);
    write_reg(REG_FIXED_WEIGHT, {8'b0, fw});
    write_reg(REG_WEIGHT_MAX, {8'b0, wm});
    write_reg(REG_WEIGHT_STEP, {8'b0, ws});
    n_settings++;
  endtask

  // sample offset from the current filter output, clamped to 16 bits
  function automatic logic [15:0] nudge(int delta);
    int v;
    v = int'(sb.last_out) + delta;
    if (v > 65535) v = 65535;
    if (v < 0) v = 0;
    return 16'(v);
  endfunction

  function automatic logic [7:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 30) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly ramps (runs in one direction, so the weight climbs), with sizes
  // around the threshold, held values, reversals, rail hits and noise.
  function automatic logic [15:0] pick_sample();
    int unsigned r;
    int mag;
    int v;
    r = $urandom_range(0, 99);
    if (r >= 88) return 16'($urandom);
    if (r >= 78) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if (r >= 63) return sb.last_out;
    if (r >= 55) trend_up = !trend_up;
    case ($urandom_range(0, 2))
      0: mag = $urandom_range(1, 3);
      1: begin
        mag = int'(sb.thresh) - 1 + int'($urandom_range(0, 2));
        if (mag < 1) mag = 1;
      end
      default: mag = $urandom_range(1, 4000);
    endcase
    v = int'(sb.last_out) + (trend_up ? mag : -mag);
    if (v > 65535) begin
      v = 65535;
      trend_up = 1'b0;
    end else if (v < 0) begin
      v = 0;
      trend_up = 1'b1;
    end
    return 16'(v);
  endfunction

  initial begin : stimulus
    int unsigned r;
    logic [15:0] thr;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_ACCEL_THRESHOLD;
    cfg_wdata     = '0;
    idle_on       = 1'b1;
    trend_up      = 1'b1;
    n_settings    = 0;
    sb = new();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: fixed weight 128; rails, midpoint, an unchanged sample
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(sb.last_out);
    send_sample(16'h0001);

    // fixed weight at both extremes
    apply_config(16'd0, 8'd255, 8'd255, 8'd20);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    apply_config(16'd0, 8'd0, 8'd255, 8'd20);
    send_sample(16'hFFFF);
    send_sample(16'h1234);

    // adaptive, minimum threshold, maximum step: sum 255+255 clamps to max
    apply_config(16'd1, 8'd128, 8'd255, 8'd255);
    send_sample(nudge(100));
    send_sample(nudge(100));
    send_sample(nudge(100));
    send_sample(sb.last_out);     // no change after a rise: weight drops
    send_sample(sb.last_out);     // repeated no change: weight grows by one
    send_sample(nudge(-50));
    send_sample(nudge(-50));

    // maximum threshold: every change counts as small
    apply_config(16'hFFFF, 8'd128, 8'd255, 8'd255);
    send_sample(nudge(30000));
    send_sample(nudge(30000));

    // zero step, then maximum weight of zero
    apply_config(16'd10, 8'd128, 8'd200, 8'd0);
    send_sample(nudge(5));
    send_sample(nudge(50));
    apply_config(16'd10, 8'd128, 8'd0, 8'd77);
    send_sample(nudge(-500));
    send_sample(nudge(-500));

    // mode switch to fixed and back: adaptive state carries across
    apply_config(16'd0, 8'd64, 8'd200, 8'd0);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    apply_config(16'd10, 8'd64, 8'd3, 8'd255);
    send_sample(nudge(400));
    send_sample(nudge(400));

    // random phases, each with its own settings and idling mode
    for (int p = 0; p < RandPhases; p++) begin
      r = $urandom_range(0, 99);
      if (r < 30) thr = 16'd0;
      else if (r < 45) thr = 16'd1;
      else if (r < 55) thr = 16'hFFFF;
      else if (r < 80) thr = 16'($urandom_range(1, 300));
      else thr = 16'($urandom_range(1, 65535));
      apply_config(thr, pick_weight(), pick_weight(), pick_weight());
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PhaseItems; i++) send_sample(pick_sample());
    end

    drain_results();
    repeat (4) @(negedge clk);

    $display("Ran %0d samples over %0d register settings: %0d fixed-weight, %0d adaptive",
             sb.n_samples, n_settings + 1, sb.n_fixed, sb.n_adaptive);
    $display("Checked %0d results; peak adaptive weight %0d", sb.n_checked, sb.peak_wt);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/afl_pkg.sv
design/afl_cfg.sv
design/afl_core.sv
design/adaptive_first_order_lag_filter.sv
design/afl_checker.sv
bench/tb.sv
